[design/msfl_pkg.sv]
// ----------------------------------------------------------------------------
// msfl_pkg
// Shared types and codes for the multi-stack shared free list.
// ----------------------------------------------------------------------------
package msfl_pkg;

  localparam int STACK_ID_W = 3;
  localparam int DATA_W     = 32;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_POP
  } state_t;

  typedef logic [STACK_ID_W-1:0]    stack_id_t;
  typedef logic signed [DATA_W-1:0] data_t;

endpackage

[design/msfl_if.sv]
// ----------------------------------------------------------------------------
// msfl_in_if / msfl_out_if
// Valid/ready channels for operations and their results.
// ----------------------------------------------------------------------------
interface msfl_in_if
  import msfl_pkg::*;
();
  logic      valid;
  logic      ready;
  op_t       op;
  stack_id_t stack_id;
  data_t     push_value;

  modport source (output valid, output op, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input op, input stack_id, input push_value,
                  output ready);
endinterface

interface msfl_out_if
  import msfl_pkg::*;
();
  logic    valid;
  logic    ready;
  data_t   pop_value;
  status_t status;

  modport source (output valid, output pop_value, output status, input ready);
  modport sink   (input valid, input pop_value, input status, output ready);
endinterface

[design/msfl_ram.sv]
// ----------------------------------------------------------------------------
// msfl_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data held while the read enable is low.
// ----------------------------------------------------------------------------
module msfl_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/multi_stack_shared_free_list.sv]
// ----------------------------------------------------------------------------
// multi_stack_shared_free_list
// Several LIFO stacks sharing one slot store, with a linked free list.
//
//   channel  dir  signals                             accepted when
//   in_ch    in   op, stack_id, push_value            valid && ready
//   out_ch   out  pop_value, status                   valid && ready
//
// A push reads the head pointer and the free-list slot, then writes back;
// a pop of a non-empty stack makes one more read of the top slot before the
// write-back, since the slot memory has a single read port. A new item is
// taken only from idle.
// Reset is immediate: untouched slot links are implied by a fill mark, so
// no clearing pass runs. A stalled result holds the sequencer in its last
// state with nothing written back until the output register frees up.
// ----------------------------------------------------------------------------
module multi_stack_shared_free_list
  import msfl_pkg::*;
#(
  parameter int NUM_STACKS  = 8,
  parameter int NUM_SLOTS   = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  msfl_in_if.sink     in_ch,
  msfl_out_if.source  out_ch
);

  localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int AW = $clog2(NUM_SLOTS);
  localparam int PW = $clog2(NUM_SLOTS + 1);
  localparam logic [PW-1:0] NULL_PTR = PW'(NUM_SLOTS);

  state_t state_r, state_nxt;

  logic                   op_pop_r;
  logic [SW-1:0]          sid_r;
  data_t                  val_r;
  logic                   hvld_r;
  logic [PW-1:0]          slot_r, slot_nxt;
  logic [PW-1:0]          fh_r, fh_nxt;
  logic [PW-1:0]          hw_r, hw_nxt;
  logic [NUM_STACKS-1:0]  hv_r;

  logic                   accept;
  logic                   out_free;
  logic [SW-1:0]          sid_w;
  logic [6:0]             sid_tmp;

  logic                   hd_we, hd_re;
  logic [PW-1:0]          hd_wdata, hd_rdata;
  logic                   sl_we, sl_re;
  logic [AW-1:0]          sl_waddr, sl_raddr;
  logic [PW+VALUE_WIDTH-1:0] sl_wdata, sl_rdata;
  logic [PW-1:0]          sl_link;
  logic [VALUE_WIDTH-1:0] sl_value;
  logic [VALUE_WIDTH-1:0] store_val;
  logic [PW-1:0]          head_ptr;

  logic                   out_ld;
  data_t                  res_val;
  status_t                res_status;
  logic                   out_valid_r;
  data_t                  pop_value_r;
  status_t                status_r;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // wrap the stack id onto the configured stack count
  always_comb begin
    sid_tmp = {4'd0, in_ch.stack_id};
    for (int i = 0; i < 8; i++) begin
      if (sid_tmp >= 7'(NUM_STACKS)) begin
        sid_tmp = sid_tmp - 7'(NUM_STACKS);
      end
    end
    sid_w = SW'(sid_tmp);
  end

  assign sl_link   = sl_rdata[PW+VALUE_WIDTH-1:VALUE_WIDTH];
  assign sl_value  = sl_rdata[VALUE_WIDTH-1:0];
  assign store_val = VALUE_WIDTH'(val_r);
  assign head_ptr  = hvld_r ? hd_rdata : NULL_PTR;

  msfl_ram #(
    .DEPTH (NUM_STACKS),
    .WIDTH (PW)
  ) u_head_ram (
    .clk   (clk),
    .we    (hd_we),
    .waddr (sid_r),
    .wdata (hd_wdata),
    .re    (hd_re),
    .raddr (sid_w),
    .rdata (hd_rdata)
  );

  msfl_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (PW + VALUE_WIDTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (sl_we),
    .waddr (sl_waddr),
    .wdata (sl_wdata),
    .re    (sl_re),
    .raddr (sl_raddr),
    .rdata (sl_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (op_pop_r && head_ptr < NULL_PTR) begin
          state_nxt = ST_POP;
        end else if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    in_ch.ready = 1'b0;
    hd_re       = 1'b0;
    hd_we       = 1'b0;
    hd_wdata    = fh_r;
    sl_re       = 1'b0;
    sl_raddr    = fh_r[AW-1:0];
    sl_we       = 1'b0;
    sl_waddr    = fh_r[AW-1:0];
    sl_wdata    = {head_ptr, store_val};
    fh_nxt      = fh_r;
    hw_nxt      = hw_r;
    slot_nxt    = slot_r;
    out_ld      = 1'b0;
    res_val     = '0;
    res_status  = STATUS_OK;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (accept) begin
          hd_re = 1'b1;
          sl_re = 1'b1;
        end
      end
      ST_LOOK: begin
        if (!op_pop_r) begin
          if (out_free) begin
            out_ld = 1'b1;
            if (fh_r >= NULL_PTR) begin
              res_status = STATUS_OVERFLOW;
            end else begin
              sl_we = 1'b1;
              hd_we = 1'b1;
              // slots at or above the fill mark still hold their reset link
              fh_nxt = (fh_r >= hw_r) ? fh_r + PW'(1) : sl_link;
              hw_nxt = (fh_r == hw_r) ? hw_r + PW'(1) : hw_r;
            end
          end
        end else if (head_ptr >= NULL_PTR) begin
          if (out_free) begin
            out_ld     = 1'b1;
            res_val    = '1;
            res_status = STATUS_UNDERFLOW;
          end
        end else begin
          sl_re    = 1'b1;
          sl_raddr = head_ptr[AW-1:0];
          slot_nxt = head_ptr;
        end
      end
      ST_POP: begin
        if (out_free) begin
          out_ld   = 1'b1;
          res_val  = data_t'(32'($signed(sl_value)));
          hd_we    = 1'b1;
          hd_wdata = sl_link;
          sl_we    = 1'b1;
          sl_waddr = slot_r[AW-1:0];
          sl_wdata = {fh_r, sl_value};
          fh_nxt   = slot_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fh_r    <= '0;
      hw_r    <= '0;
      hv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fh_r    <= fh_nxt;
      hw_r    <= hw_nxt;
      if (hd_we) begin
        hv_r[sid_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_pop_r <= (in_ch.op == OP_POP);
      sid_r    <= sid_w;
      val_r    <= in_ch.push_value;
      hvld_r   <= hv_r[sid_w];
    end
    slot_r <= slot_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      pop_value_r <= res_val;
      status_r    <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pop_value = pop_value_r;
  assign out_ch.status    = status_r;

endmodule
